// ----- rtl/mssr_pkg.sv -----
package mssr_pkg;

    // Fixed channel slots in the result item
    localparam int MAX_CH = 4;

    localparam int ANGLE_W = 8;
    localparam int PHYS_W  = 8;
    localparam int CFG_REGS = 2 * MAX_CH;
    localparam int PADDR_W  = $clog2(CFG_REGS) + 2;

    localparam logic signed [ANGLE_W-1:0] LIMIT_LOW_RST  = -8'sd90;
    localparam logic signed [ANGLE_W-1:0] LIMIT_HIGH_RST = 8'sd90;

    localparam logic signed [9:0]    PHYS_CENTER = 10'sd90;
    localparam logic signed [9:0]    PHYS_MAX_S  = 10'sd180;
    localparam logic [PHYS_W-1:0]    PHYS_MAX    = 8'd180;
    localparam logic [PHYS_W-1:0]    PHYS_IDLE   = 8'd90;

    // req_type codes
    localparam logic REQ_SET  = 1'b0;
    localparam logic REQ_TICK = 1'b1;

    typedef logic signed [ANGLE_W-1:0] angle_t;

    typedef struct packed {
        logic                req_type;
        logic [2:0]          channel;
        logic signed [7:0]   target_angle;
    } req_item_t;

    typedef struct packed {
        logic [7:0] phys_angle_0;
        logic [7:0] phys_angle_1;
        logic [7:0] phys_angle_2;
        logic [7:0] phys_angle_3;
        logic [3:0] moved_mask;
        logic       any_moving;
    } rsp_item_t;

endpackage

// ----- rtl/multi_servo_slew_ramp.sv -----
// Slew-limited position ramp for up to four servo channels.
// Request channel (req_valid/req_stall/req_data): a set-target item clamps
// target_angle to the channel's low/high limits and stores it; a channel
// number at or above CHANNELS changes nothing. A tick item steps every
// channel's current angle one degree toward its target.
// Response channel (rsp_valid/rsp_stall/rsp_data): one item per request with
// the physical angle of each channel (90 minus logical, held to 0..180),
// the mask of channels that stepped, and an any-moved flag.
// Each accepted item's result is registered in the output register, or in the skid
// register while the output is stalled; one item per cycle is sustained while rsp_stall is low.
// A two-entry output buffer (output register plus skid register) absorbs a
// stall: while the receiver stalls, one more item is taken into the skid
// register, then req_stall rises until the output drains.
// Limits are written over the APB port at byte address 4*i, low then high
// per channel; write them only while the block is idle.
// Reset: positions and targets go to 0 degrees, limits to -90 and 90, both
// output entries empty.
module multi_servo_slew_ramp #(
    parameter int CHANNELS = mssr_pkg::MAX_CH
) (
    input  logic                          clk,
    input  logic                          rst_n,

    input  logic                          req_valid,
    output logic                          req_stall,
    input  mssr_pkg::req_item_t           req_data,

    output logic                          rsp_valid,
    input  logic                          rsp_stall,
    output mssr_pkg::rsp_item_t           rsp_data,

    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [mssr_pkg::PADDR_W-1:0]  paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);

    localparam int MAX_CH   = mssr_pkg::MAX_CH;
    localparam int CFG_REGS = mssr_pkg::CFG_REGS;
    localparam int IDX_W    = $clog2(CFG_REGS);

    mssr_pkg::angle_t limit_low_reg  [MAX_CH];
    mssr_pkg::angle_t limit_high_reg [MAX_CH];
    mssr_pkg::angle_t cur_reg        [CHANNELS];
    mssr_pkg::angle_t cur_next       [CHANNELS];
    mssr_pkg::angle_t tgt_reg        [CHANNELS];
    mssr_pkg::angle_t tgt_next       [CHANNELS];

    logic [7:0]       phys   [MAX_CH];
    logic [MAX_CH-1:0] moved;

    logic             cfg_wr;
    logic [IDX_W-1:0] cfg_idx;
    logic             accept;
    logic             is_tick;

    mssr_pkg::rsp_item_t result;
    mssr_pkg::rsp_item_t out_reg, out_next;
    mssr_pkg::rsp_item_t skid_reg, skid_next;
    logic out_valid_reg, out_valid_next;
    logic skid_valid_reg, skid_valid_next;

    // ---------------- configuration port ----------------
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = paddr[mssr_pkg::PADDR_W-1:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_CH; i++)
            begin
                limit_low_reg[i]  <= mssr_pkg::LIMIT_LOW_RST;
                limit_high_reg[i] <= mssr_pkg::LIMIT_HIGH_RST;
            end
        end
        else if (cfg_wr)
        begin
            for (int i = 0; i < MAX_CH; i++)
            begin
                if (cfg_idx == IDX_W'(2 * i))
                    limit_low_reg[i] <= pwdata[7:0];
                if (cfg_idx == IDX_W'(2 * i + 1))
                    limit_high_reg[i] <= pwdata[7:0];
            end
        end
    end

    always_comb
    begin
        prdata = '0;
        for (int i = 0; i < MAX_CH; i++)
        begin
            if (cfg_idx == IDX_W'(2 * i))
                prdata = 32'(signed'(limit_low_reg[i]));
            if (cfg_idx == IDX_W'(2 * i + 1))
                prdata = 32'(signed'(limit_high_reg[i]));
        end
    end

    // ---------------- request side ----------------
    assign req_stall = skid_valid_reg;
    assign accept    = req_valid && !skid_valid_reg;
    assign is_tick   = (req_data.req_type == mssr_pkg::REQ_TICK);

    for (genvar i = 0; i < MAX_CH; i++)
    begin : g_ch
        if (i < CHANNELS)
        begin : g_used
            logic             set_hit;
            logic             step_up;
            logic             step_dn;
            mssr_pkg::angle_t clamped;
            logic signed [9:0] phys_raw;

            assign set_hit = (req_data.req_type == mssr_pkg::REQ_SET)
                             && (req_data.channel == 3'(i));
            assign step_up = cur_reg[i] < tgt_reg[i];
            assign step_dn = cur_reg[i] > tgt_reg[i];

            // with crossed limits, a target under the low limit gets low, else high
            always_comb
            begin
                priority if (req_data.target_angle < limit_low_reg[i])
                    clamped = limit_low_reg[i];
                else if (req_data.target_angle > limit_high_reg[i])
                    clamped = limit_high_reg[i];
                else
                    clamped = req_data.target_angle;
            end

            always_comb
            begin
                tgt_next[i] = set_hit ? clamped : tgt_reg[i];
                cur_next[i] = cur_reg[i];
                if (is_tick && step_up)
                    cur_next[i] = cur_reg[i] + 8'sd1;
                else if (is_tick && step_dn)
                    cur_next[i] = cur_reg[i] - 8'sd1;
            end

            assign moved[i] = is_tick && (step_up || step_dn);

            // physical angle of the position after this item
            assign phys_raw = mssr_pkg::PHYS_CENTER - 10'(signed'(cur_next[i]));
            always_comb
            begin
                priority if (phys_raw < 10'sd0)
                    phys[i] = '0;
                else if (phys_raw > mssr_pkg::PHYS_MAX_S)
                    phys[i] = mssr_pkg::PHYS_MAX;
                else
                    phys[i] = phys_raw[7:0];
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    cur_reg[i] <= '0;
                    tgt_reg[i] <= '0;
                end
                else if (accept)
                begin
                    cur_reg[i] <= cur_next[i];
                    tgt_reg[i] <= tgt_next[i];
                end
            end
        end
        else
        begin : g_unused
            assign moved[i] = 1'b0;
            assign phys[i]  = mssr_pkg::PHYS_IDLE;
        end
    end

    always_comb
    begin
        result.phys_angle_0 = phys[0];
        result.phys_angle_1 = phys[1];
        result.phys_angle_2 = phys[2];
        result.phys_angle_3 = phys[3];
        result.moved_mask   = moved;
        result.any_moving   = |moved;
    end

    // ---------------- output register and skid ----------------
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_next        = out_reg;
        skid_valid_next = skid_valid_reg;
        skid_next       = skid_reg;

        // drain the output register on a transfer
        if (out_valid_reg && !rsp_stall)
            out_valid_next = 1'b0;

        // refill from the skid register first to keep order
        if (!out_valid_next && skid_valid_reg)
        begin
            out_valid_next  = 1'b1;
            out_next        = skid_reg;
            skid_valid_next = 1'b0;
        end

        if (accept)
        begin
            if (!out_valid_next)
            begin
                out_valid_next = 1'b1;
                out_next       = result;
            end
            else
            begin
                skid_valid_next = 1'b1;
                skid_next       = result;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign rsp_valid = out_valid_reg;
    assign rsp_data  = out_reg;

endmodule
